FILE: src/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types and constants for the integer literal parser: character codes,
// radix kind codes and the classified character item that the front end
// hands to the parser through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

    // Default accumulator width
    localparam int VALUE_BITS_DEF = 64;

    // Entries of the queue between front end and parser
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_B = 8'h62;

    // Radix kind codes on the result channel
    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_HEX = 2'd1;
    localparam logic [1:0] KIND_OCT = 2'd2;
    localparam logic [1:0] KIND_BIN = 2'd3;

    // One classified character item
    typedef struct packed {
        logic       first;
        logic       eot;
        logic       minus;
        logic       lower_x;
        logic       lower_b;
        logic       is_digit;
        logic [3:0] digit;
    } ilp_class_t;

endpackage

`default_nettype wire

FILE: src/ilp_front.sv
// ----------------------------------------------------------------------------
// ilp_front
// Input side: accepts character items while the queue has room and classifies
// each character into digit value and marker flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_char_code,
    input  wire logic              s_first,
    input  wire logic              s_end_of_text,
    input  wire logic              q_full,
    output logic                   q_push,
    output ilp_pkg::ilp_class_t    q_data
);

    logic [7:0] ofs_dec;
    logic [7:0] ofs_low;
    logic [7:0] ofs_upp;

    // Accept whenever the queue has a free entry
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the character
    always_comb begin
        ofs_dec = s_char_code - ilp_pkg::CH_ZERO;
        ofs_low = s_char_code - ilp_pkg::CH_LOWER_A + 8'd10;
        ofs_upp = s_char_code - ilp_pkg::CH_UPPER_A + 8'd10;

        q_data          = '0;
        q_data.first    = s_first;
        q_data.eot      = s_end_of_text;
        q_data.minus    = (s_char_code == ilp_pkg::CH_MINUS);
        q_data.lower_x  = (s_char_code == ilp_pkg::CH_LOWER_X);
        q_data.lower_b  = (s_char_code == ilp_pkg::CH_LOWER_B);

        if (s_char_code >= ilp_pkg::CH_ZERO && s_char_code <= ilp_pkg::CH_NINE) begin
            q_data.is_digit = 1'b1;
            q_data.digit    = ofs_dec[3:0];
        end else if (s_char_code >= ilp_pkg::CH_LOWER_A &&
                     s_char_code <= ilp_pkg::CH_LOWER_F) begin
            q_data.is_digit = 1'b1;
            q_data.digit    = ofs_low[3:0];
        end else if (s_char_code >= ilp_pkg::CH_UPPER_A &&
                     s_char_code <= ilp_pkg::CH_UPPER_F) begin
            q_data.is_digit = 1'b1;
            q_data.digit    = ofs_upp[3:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/ilp_queue.sv
// ----------------------------------------------------------------------------
// ilp_queue
// Short queue of classified items between front end and parser, so that
// either side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_queue #(
    localparam int PTR_W = (ilp_pkg::QUEUE_DEPTH > 1) ? $clog2(ilp_pkg::QUEUE_DEPTH) : 1,
    localparam int CNT_W = $clog2(ilp_pkg::QUEUE_DEPTH + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire ilp_pkg::ilp_class_t  wr_data,
    output logic                      full,
    output logic                      valid,
    output ilp_pkg::ilp_class_t       rd_data,
    input  wire logic                 pop,
    output logic [CNT_W-1:0]          count
);

    ilp_pkg::ilp_class_t entry_reg [ilp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full    = (count_reg == CNT_W'(ilp_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ilp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ilp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/ilp_back.sv
// ----------------------------------------------------------------------------
// ilp_back
// Parser: takes one classified item a cycle from the queue, steps the literal
// state machine with a constant-radix shift-add, and loads finished results
// into the output register; an item that closes a literal waits while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_back #(
    parameter int VALUE_BITS = ilp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_wr_data,
    input  wire logic                   q_valid,
    input  wire ilp_pkg::ilp_class_t    q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [VALUE_BITS-1:0]       m_value,
    output logic [7:0]                  m_consumed,
    output logic [1:0]                  m_radix_kind,
    output logic                        m_negative,
    output logic                        m_overflow
);

    // Parse phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_DEC    = 3'd4;
    localparam logic [2:0] PH_HEX    = 3'd5;
    localparam logic [2:0] PH_OCT    = 3'd6;
    localparam logic [2:0] PH_BIN    = 3'd7;

    localparam logic [4:0] RADIX_2  = 5'd2;
    localparam logic [4:0] RADIX_8  = 5'd8;
    localparam logic [4:0] RADIX_10 = 5'd10;
    localparam logic [4:0] RADIX_16 = 5'd16;

    localparam int EXT_W = VALUE_BITS + 4;

    // Parse state
    logic [2:0]            phase_reg, phase_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [7:0]            count_reg, count_next;
    logic                  sign_reg, sign_next;
    logic                  wrap_reg, wrap_next;
    logic                  signed_mode_reg;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [7:0]            consumed_reg;
    logic [1:0]            kind_reg;
    logic                  neg_reg;
    logic                  ovf_reg;

    // Working copy after an optional restart
    logic [2:0]            w_phase;
    logic [VALUE_BITS-1:0] w_acc;
    logic [7:0]            w_count;
    logic                  w_sign;
    logic                  w_wrap;

    logic                  emit_old;
    logic                  close;
    logic                  emit;
    logic                  out_free;
    logic                  load;

    logic [4:0]            radix;
    logic                  dig_ok;
    logic [EXT_W-1:0]      acc_ext;
    logic [EXT_W-1:0]      prod;
    logic [EXT_W-1:0]      sum;
    logic [7:0]            count_inc;

    logic [2:0]            src_phase;
    logic [VALUE_BITS-1:0] src_acc;
    logic [7:0]            src_count;
    logic                  src_sign;
    logic                  src_wrap;
    logic [VALUE_BITS-1:0] src_value;
    logic [1:0]            src_kind;

    // Restart the working state on a first character
    always_comb begin
        w_phase  = phase_reg;
        w_acc    = acc_reg;
        w_count  = count_reg;
        w_sign   = sign_reg;
        w_wrap   = wrap_reg;
        emit_old = 1'b0;
        if (q_data.eot) begin
            emit_old = (phase_reg != PH_IDLE);
        end else if (q_data.first) begin
            emit_old = (phase_reg != PH_IDLE);
            w_phase  = PH_START;
            w_acc    = '0;
            w_count  = '0;
            w_sign   = 1'b0;
            w_wrap   = 1'b0;
        end
    end

    // Radix of the digit that this phase would take
    always_comb begin
        case (w_phase)
            PH_HEX:           radix = RADIX_16;
            PH_ZERO, PH_OCT:  radix = RADIX_8;
            PH_BIN:           radix = RADIX_2;
            default:          radix = RADIX_10;
        endcase
        dig_ok = q_data.is_digit && ({1'b0, q_data.digit} < radix);
    end

    // Shift-add one digit into the accumulator
    always_comb begin
        acc_ext = EXT_W'(w_acc);
        case (radix)
            RADIX_2:  prod = acc_ext << 1;
            RADIX_8:  prod = acc_ext << 3;
            RADIX_16: prod = acc_ext << 4;
            default:  prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
        sum       = prod + EXT_W'(q_data.digit);
        count_inc = (w_count == 8'hFF) ? w_count : w_count + 8'd1;
    end

    // Step the literal state machine
    always_comb begin
        phase_next = w_phase;
        acc_next   = w_acc;
        count_next = w_count;
        sign_next  = w_sign;
        wrap_next  = w_wrap;
        close      = 1'b0;
        if (q_data.eot) begin
            phase_next = PH_IDLE;
        end else begin
            case (w_phase)
                PH_START, PH_SIGNED: begin
                    if (w_phase == PH_START && signed_mode_reg && q_data.minus) begin
                        sign_next  = 1'b1;
                        count_next = count_inc;
                        phase_next = PH_SIGNED;
                    end else if (q_data.is_digit && q_data.digit == 4'd0) begin
                        count_next = count_inc;
                        phase_next = PH_ZERO;
                    end else if (dig_ok) begin
                        acc_next   = sum[VALUE_BITS-1:0];
                        wrap_next  = w_wrap | (|sum[EXT_W-1:VALUE_BITS]);
                        count_next = count_inc;
                        phase_next = PH_DEC;
                    end else begin
                        close = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (q_data.lower_x) begin
                        count_next = count_inc;
                        phase_next = PH_HEX;
                    end else if (q_data.lower_b) begin
                        count_next = count_inc;
                        phase_next = PH_BIN;
                    end else if (dig_ok) begin
                        acc_next   = sum[VALUE_BITS-1:0];
                        wrap_next  = w_wrap | (|sum[EXT_W-1:VALUE_BITS]);
                        count_next = count_inc;
                        phase_next = PH_OCT;
                    end else begin
                        close = 1'b1;
                    end
                end
                PH_DEC, PH_HEX, PH_OCT, PH_BIN: begin
                    if (dig_ok) begin
                        acc_next   = sum[VALUE_BITS-1:0];
                        wrap_next  = w_wrap | (|sum[EXT_W-1:VALUE_BITS]);
                        count_next = count_inc;
                    end else begin
                        close = 1'b1;
                    end
                end
                default: begin
                    close = 1'b0;
                end
            endcase
            if (close) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Pick the literal to report and format it
    always_comb begin
        emit      = emit_old || close;
        src_phase = emit_old ? phase_reg : w_phase;
        src_acc   = emit_old ? acc_reg   : w_acc;
        src_count = emit_old ? count_reg : w_count;
        src_sign  = emit_old ? sign_reg  : w_sign;
        src_wrap  = emit_old ? wrap_reg  : w_wrap;
        src_value = src_sign ? (~src_acc + 1'b1) : src_acc;
        case (src_phase)
            PH_HEX:          src_kind = ilp_pkg::KIND_HEX;
            PH_ZERO, PH_OCT: src_kind = ilp_pkg::KIND_OCT;
            PH_BIN:          src_kind = ilp_pkg::KIND_BIN;
            default:         src_kind = ilp_pkg::KIND_DEC;
        endcase
    end

    // Take an item unless its result finds the output register occupied
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && (!emit || out_free);
    assign load     = q_pop && emit;

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            acc_reg         <= '0;
            count_reg       <= '0;
            sign_reg        <= 1'b0;
            wrap_reg        <= 1'b0;
            signed_mode_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                count_reg <= count_next;
                sign_reg  <= sign_next;
                wrap_reg  <= wrap_next;
            end
            if (cfg_wr_en) begin
                signed_mode_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg    <= src_value;
            consumed_reg <= src_count;
            kind_reg     <= src_kind;
            neg_reg      <= src_sign;
            ovf_reg      <= src_wrap;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = value_reg;
    assign m_consumed   = consumed_reg;
    assign m_radix_kind = kind_reg;
    assign m_negative   = neg_reg;
    assign m_overflow   = ovf_reg;

endmodule

`default_nettype wire

FILE: src/integer_literal_parser_core.sv
// ----------------------------------------------------------------------------
// integer_literal_parser_core
// Streaming parser for one C-style integer literal per run of characters:
// optional minus, 0x / 0b / leading-zero radix prefixes, wrapping value with
// overflow flag and saturating length.
//
//   Port group   Direction  Handshake          Payload
//   s_*          in         s_valid/s_ready    char_code, first, end_of_text
//   m_*          out        m_valid/m_ready    value, consumed, radix_kind,
//                                              negative, overflow
//   cfg_*        in         cfg_wr_en          cfg_wr_data (signed mode)
//
// One character item a cycle sustained while the output register is free; an
// item that closes a literal passes through the queue, and popping it loads
// the output register and raises m_valid.
// Each parse step is one shift-add of the accumulator by a constant radix.
// The two-entry queue lets input accept while the output register is stalled.
// Reset is synchronous: queue empty, parser idle, signed mode on, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_parser_core #(
    parameter int VALUE_BITS = ilp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_char_code,
    input  wire logic                  s_first,
    input  wire logic                  s_end_of_text,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [VALUE_BITS-1:0]      m_value,
    output logic [7:0]                 m_consumed,
    output logic [1:0]                 m_radix_kind,
    output logic                       m_negative,
    output logic                       m_overflow
);

    localparam int CNT_W = $clog2(ilp_pkg::QUEUE_DEPTH + 1);

    ilp_pkg::ilp_class_t push_data;
    ilp_pkg::ilp_class_t pop_data;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_valid;
    logic [CNT_W-1:0]    q_count;

    // Accept and classify
    ilp_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_first       (s_first),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_data)
    );

    // Decouple front end and parser
    ilp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (push_data),
        .full    (q_full),
        .valid   (q_valid),
        .rd_data (pop_data),
        .pop     (q_pop),
        .count   (q_count)
    );

    // Parse and emit
    ilp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (q_valid),
        .q_data       (pop_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_consumed   (m_consumed),
        .m_radix_kind (m_radix_kind),
        .m_negative   (m_negative),
        .m_overflow   (m_overflow)
    );

    // Reset leaves the input open and no result pending
    a_reset_ready : assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    a_reset_no_result : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // Parser never takes from an empty queue
    a_pop_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // An accepted item that the parser does not take stays queued
    a_push_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> (q_count == CNT_W'($past(q_count) + 1'b1)))
        else $error("queue lost an accepted item");

endmodule

`default_nettype wire
